>>> sv/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the pedestal servo.
// ----------------------------------------------------------------------------
package aps_pkg;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_UPDATE = 2'd1,
    KIND_WRITE  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  localparam logic [1:0] REG_VETO   = 2'd0;
  localparam logic [1:0] REG_TARGET = 2'd1;
  localparam logic [1:0] REG_MINCNT = 2'd2;

  localparam logic [15:0] TARGET_RESET = 16'd100;
  localparam logic [15:0] MINCNT_RESET = 16'd1500;
  localparam logic [15:0] ZERO_STEP    = 16'd50;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  module_req;
    logic [4:0]  adc;
    logic [2:0]  channel;
    logic [1:0]  ped_index;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic        updated;
    logic [15:0] pedestal_value;
    logic [15:0] position;
    logic        sample_dropped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_RMW, ST_SCAN, ST_CHECK, ST_SERVO_RD,
    ST_DIV, ST_SERVO_WR, ST_WIPE, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic clr_step;   // write zero at the sweep index, advance
    logic clr_ped;    // also zero pedestal and position entries
    logic acc_rd;     // read accumulator at item address
    logic acc_wr;     // finish the sample read-modify-write
    logic ped_op;     // pedestal write or read
    logic scan_step;  // read/accumulate one count, advance
    logic chk_start;  // start mean-count multiply
    logic srv_rd;     // read one servo entry
    logic div_start;  // start divider
    logic srv_wr;     // write servo results, advance
    logic res_upd;    // set updated flag
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic scan_last;
    logic chk_pass;
    logic div_done;
    logic srv_last;
  } sts_t;

  // ADC of each (channel, pedestal) pair in four-by-four mode
  function automatic logic [4:0] quad_adc(input logic [1:0] ch, input logic [1:0] p);
    logic [4:0] r;
    begin
      r = 5'd0;
      unique case ({ch, p})
        4'h0: r = 5'd10; 4'h1: r = 5'd8;  4'h2: r = 5'd11; 4'h3: r = 5'd9;
        4'h4: r = 5'd14; 4'h5: r = 5'd12; 4'h6: r = 5'd15; 4'h7: r = 5'd13;
        4'h8: r = 5'd22; 4'h9: r = 5'd20; 4'hA: r = 5'd23; 4'hB: r = 5'd21;
        4'hC: r = 5'd26; 4'hD: r = 5'd24; 4'hE: r = 5'd27; 4'hF: r = 5'd25;
        default: r = 5'd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> sv/aps_ctrl.sv
// ----------------------------------------------------------------------------
// aps_ctrl
// Sequencer of the pedestal servo: handshake, clearing pass, update walk.
// ----------------------------------------------------------------------------
module aps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output aps_pkg::cmd_t  cmd,
  input  aps_pkg::sts_t  sts
);
  import aps_pkg::*;

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.clr_ped  = 1'b1;
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_kind)
            KIND_ADD:    state_next = ST_RD;
            KIND_UPDATE: state_next = ST_SCAN;
            default:     state_next = ST_RD;
          endcase
        end
      end
      ST_RD: begin
        cmd.acc_rd = 1'b1;
        cmd.ped_op = 1'b1;
        state_next = ST_RMW;
      end
      ST_RMW: begin
        cmd.acc_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.chk_start = 1'b1;
        state_next = sts.chk_pass ? ST_SERVO_RD : ST_DONE;
      end
      ST_SERVO_RD: begin
        cmd.srv_rd = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_start = 1'b1;
        if (sts.div_done) state_next = ST_SERVO_WR;
      end
      ST_SERVO_WR: begin
        cmd.srv_wr = 1'b1;
        state_next = sts.srv_last ? ST_WIPE : ST_SERVO_RD;
      end
      ST_WIPE: begin
        cmd.clr_step = 1'b1;
        cmd.res_upd  = 1'b1;
        if (sts.sweep_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // no input transfer while a result is held
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  // update walk never starts outside a check
  assert property (@(posedge clk) disable iff (rst)
      (state == ST_SERVO_RD) |-> ($past(state) == ST_CHECK || $past(state) == ST_SERVO_WR))
    else $error("servo walk entered illegally");
  // a result is held until transferred
  assert property (@(posedge clk) disable iff (rst)
      (out_valid && !out_ready) |=> out_valid)
    else $error("result lost");

endmodule

>>> sv/aps_datapath.sv
// ----------------------------------------------------------------------------
// aps_datapath
// Accumulator, pedestal and position memories, serial divider and servo step.
// ----------------------------------------------------------------------------
module aps_datapath #(
  parameter int MODULES         = 16,
  parameter int ADCS_PER_MODULE = 32,
  parameter int COUNT_BITS      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  aps_pkg::in_item_t in_item,
  input  logic              veto_mode,
  input  logic [15:0]       target_position,
  input  logic [15:0]       min_mean_count,
  input  aps_pkg::cmd_t     cmd,
  output aps_pkg::sts_t     sts,
  output aps_pkg::out_item_t res
);
  import aps_pkg::*;

  localparam int SUM_DEPTH = MODULES * ADCS_PER_MODULE;
  localparam int PED_DEPTH = MODULES * 32;
  localparam int CLR_DEPTH = (SUM_DEPTH > PED_DEPTH) ? SUM_DEPTH : PED_DEPTH;
  localparam int AW  = $clog2(SUM_DEPTH);
  localparam int PW  = $clog2(PED_DEPTH);
  localparam int XW  = $clog2(CLR_DEPTH);
  localparam int MW  = (MODULES > 1) ? $clog2(MODULES) : 1;
  localparam int ADW = $clog2(ADCS_PER_MODULE);
  localparam int TW  = COUNT_BITS + AW + 1;
  localparam int ACW = AW + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // memories
  logic [31:0]           sum_mem [SUM_DEPTH];
  logic [COUNT_BITS-1:0] cnt_mem [SUM_DEPTH];
  logic [15:0]           ped_mem [PED_DEPTH];
  logic [15:0]           pos_mem [PED_DEPTH];

  in_item_t item;
  logic [XW-1:0] sweep;    // clearing / scan index over the larger memory
  logic [31:0] sum_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [15:0] ped_rd, pos_rd;
  logic [TW-1:0]  total;
  logic [ACW-1:0] active;
  logic           scan_vld;
  logic [PW-1:0]  sidx;    // servo slot walk: module, channel, pedestal
  logic [5:0]     div_cnt;
  logic [31:0]    quo;
  logic [COUNT_BITS:0] rem;
  logic           div_busy;
  logic           div_flag;

  // item address decode
  logic [AW-1:0] acc_addr, srv_addr;
  logic [PW-1:0] ped_addr;
  logic          acc_ok, slot_ok;
  logic [MW-1:0] smod;
  logic [2:0]    sch;
  logic [1:0]    sp;
  logic [4:0]    sadc;

  always_comb begin
    acc_ok   = (32'(item.module_req) < MODULES) && (32'(item.adc) < ADCS_PER_MODULE);
    acc_addr = AW'(32'(item.module_req) * ADCS_PER_MODULE + 32'(item.adc));
    slot_ok  = (32'(item.module_req) < MODULES) &&
               (veto_mode ? (item.ped_index == 2'd0) : !item.channel[2]);
    ped_addr = PW'({32'(item.module_req), item.channel, item.ped_index});
    smod = MW'(sidx >> 5);
    if (veto_mode) begin
      sch  = sidx[2:0];
      sp   = 2'd0;
      sadc = 5'd20 + {2'b00, sidx[2:0]};
    end else begin
      sch  = {1'b0, sidx[3:2]};
      sp   = sidx[1:0];
      sadc = quad_adc(sidx[3:2], sidx[1:0]);
    end
    srv_addr = AW'(32'(smod) * ADCS_PER_MODULE + 32'(sadc));
  end

  logic [PW-1:0] srv_slot;
  assign srv_slot = PW'({32'(smod), sch, sp});

  // capture item
  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
  end

  // accumulator memory: clear sweep, sample read-modify-write, scan, servo read
  logic [AW-1:0] rd_addr;
  always_comb begin
    if (cmd.scan_step)   rd_addr = sweep[AW-1:0];
    else if (cmd.srv_rd) rd_addr = srv_addr;
    else                 rd_addr = acc_addr;
  end

  // hold read data between explicit reads
  logic rd_acc, rd_ped;
  assign rd_acc = cmd.acc_rd || cmd.scan_step || cmd.srv_rd;
  assign rd_ped = cmd.ped_op || cmd.srv_rd;

  logic [32:0] sum_new;
  logic        drop;
  assign sum_new = {1'b0, sum_rd} + {17'd0, item.value};
  assign drop    = (cnt_rd == CMAX) || sum_new[32];

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (32'(sweep) < SUM_DEPTH) begin
        sum_mem[sweep[AW-1:0]] <= '0;
        cnt_mem[sweep[AW-1:0]] <= '0;
      end
    end else if (cmd.acc_wr && item.kind == KIND_ADD && acc_ok && !drop) begin
      sum_mem[acc_addr] <= sum_new[31:0];
      cnt_mem[acc_addr] <= cnt_rd + 1'b1;
    end
    if (rd_acc) begin
      sum_rd <= sum_mem[rd_addr];
      cnt_rd <= cnt_mem[rd_addr];
    end
  end

  // pedestal and position memories
  logic [PW-1:0] pa;
  assign pa = cmd.srv_rd ? srv_slot : ped_addr;
  logic [15:0] ped_step, pos_sat;

  always_ff @(posedge clk) begin
    if (cmd.clr_ped) begin
      if (32'(sweep) < PED_DEPTH) begin
        ped_mem[sweep[PW-1:0]] <= '0;
        pos_mem[sweep[PW-1:0]] <= '0;
      end
    end else if (cmd.srv_wr) begin
      ped_mem[srv_slot] <= ped_step;
      pos_mem[srv_slot] <= pos_sat;
    end else if (cmd.ped_op && item.kind == KIND_WRITE && slot_ok) begin
      ped_mem[ped_addr] <= item.value;
    end
    if (rd_ped) begin
      ped_rd <= ped_mem[pa];
      pos_rd <= pos_mem[pa];
    end
  end

  // sweep index and scan totals
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      scan_vld <= 1'b0;
    end else begin
      scan_vld <= cmd.scan_step;
      if ((cmd.clr_step && sts.sweep_last) || (cmd.scan_step && sts.scan_last)) begin
        sweep <= '0;
      end else if (cmd.clr_step || cmd.scan_step) begin
        sweep <= sweep + 1'b1;
      end
    end
  end
  assign sts.sweep_last = sweep == XW'(CLR_DEPTH - 1);
  assign sts.scan_last  = sweep == XW'(SUM_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total  <= '0;
      active <= '0;
    end else if (scan_vld && cnt_rd != '0) begin
      total  <= total + TW'(cnt_rd);
      active <= active + 1'b1;
    end
  end

  // mean-count test: last scanned entry lands in cycle of the check
  logic [TW-1:0]  total_f;
  logic [ACW-1:0] active_f;
  logic [ACW+15:0] need;
  logic            chk_pass;
  always_comb begin
    total_f  = total  + ((cnt_rd != '0) ? TW'(cnt_rd) : '0);
    active_f = active + ((cnt_rd != '0) ? ACW'(1) : '0);
    need     = {16'd0, active_f} * {{ACW{1'b0}}, min_mean_count};
    chk_pass = (active_f != '0) &&
               ({{(ACW+16){1'b0}}, total_f} >= {{TW{1'b0}}, need});
  end
  assign sts.chk_pass = chk_pass;

  // serial divider: one quotient bit a cycle, done flag for one cycle
  logic [COUNT_BITS:0] rem_sh;
  always_comb rem_sh = {rem[COUNT_BITS-1:0], quo[31]};
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
      div_flag <= 1'b0;
    end else begin
      div_flag <= 1'b0;
      if (div_busy) begin
        if (rem_sh >= {1'b0, cnt_rd}) begin
          rem <= rem_sh - {1'b0, cnt_rd};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == 6'd1) begin
          div_busy <= 1'b0;
          div_flag <= 1'b1;
        end
      end else if (cmd.div_start && !div_flag) begin
        div_busy <= 1'b1;
        quo      <= sum_rd;
        rem      <= '0;
        div_cnt  <= 6'd32;
      end
    end
  end
  assign sts.div_done = div_flag;

  // servo step
  logic [31:0] mean;
  always_comb begin
    mean    = (cnt_rd == '0) ? 32'd0 : quo;
    pos_sat = (mean > 32'd65535) ? 16'hFFFF : mean[15:0];
    ped_step = ped_rd;
    if (mean != {16'd0, target_position}) begin
      if (sum_rd == 32'd0)
        ped_step = (ped_rd > ZERO_STEP) ? ped_rd - ZERO_STEP : 16'd0;
      else if (mean > {16'd0, target_position})
        ped_step = (ped_rd != 16'hFFFF) ? ped_rd + 16'd1 : ped_rd;
      else
        ped_step = (ped_rd != 16'd0) ? ped_rd - 16'd1 : 16'd0;
    end
  end

  // servo walk index
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      sidx <= '0;
    end else if (cmd.srv_wr) begin
      if (veto_mode) sidx <= (sidx[2:0] == 3'd7) ? sidx + PW'(25) : sidx + 1'b1;
      else           sidx <= (sidx[3:0] == 4'hF) ? sidx + PW'(17) : sidx + 1'b1;
    end
  end
  assign sts.srv_last = (32'(smod) == MODULES - 1) &&
                        (veto_mode ? (sidx[2:0] == 3'd7) : (sidx[3:0] == 4'hF));

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= '0;
    end else begin
      if (cmd.res_upd) res.updated <= 1'b1;
      if (cmd.acc_wr && item.kind == KIND_ADD && acc_ok) res.sample_dropped <= drop;
      if (cmd.acc_wr && item.kind == KIND_READ && slot_ok) begin
        res.pedestal_value <= ped_rd;
        res.position       <= pos_rd;
      end
    end
  end

  // sample never accumulated past saturation
  assert property (@(posedge clk) disable iff (rst)
      (cmd.acc_wr && item.kind == KIND_ADD && acc_ok && cnt_rd == CMAX) |=> res.sample_dropped)
    else $error("saturated sample not flagged");
  // divider finishes before the servo write
  assert property (@(posedge clk) disable iff (rst) cmd.srv_wr |-> !div_busy)
    else $error("servo write during division");
  // sweep and servo walk never overlap
  assert property (@(posedge clk) disable iff (rst) !(cmd.clr_step && cmd.srv_wr))
    else $error("clear and servo overlap");

endmodule

>>> sv/adc_pedestal_servo.sv
// ----------------------------------------------------------------------------
// adc_pedestal_servo
// Pedestal servo over per-ADC sample statistics of a digitizer crate.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | in_item_t
//   out     | output    | out_valid/out_ready| out_item_t
//   cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// Sample add, pedestal write and read: capture, memory read, write-back, then
// output wait. Update: a scan of every accumulator entry, the mean-count test
// and, if it passes, a serial 32-bit division and servo step per pedestal slot
// of the mode, then a wipe of the larger of MODULES*ADCS_PER_MODULE and
// MODULES*32 entries. After reset a like clearing pass runs before any input.
// The result register holds until transferred; input waits meanwhile.
// ----------------------------------------------------------------------------
module adc_pedestal_servo #(
  parameter int MODULES         = 16,
  parameter int ADCS_PER_MODULE = 32,
  parameter int COUNT_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  aps_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aps_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import aps_pkg::*;

  logic        veto_mode;
  logic [15:0] target_position, min_mean_count;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      veto_mode       <= 1'b0;
      target_position <= TARGET_RESET;
      min_mean_count  <= MINCNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VETO:   veto_mode       <= cfg_data[0];
        REG_TARGET: target_position <= cfg_data;
        REG_MINCNT: min_mean_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  aps_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_kind(in_data.kind), .in_ready,
    .out_valid, .out_ready, .cmd, .sts
  );

  aps_datapath #(
    .MODULES(MODULES), .ADCS_PER_MODULE(ADCS_PER_MODULE), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk, .rst, .in_item(in_data), .veto_mode, .target_position, .min_mean_count,
    .cmd, .sts, .res(out_data)
  );

endmodule

>>> bench/tb_adc_pedestal_servo.sv
// ----------------------------------------------------------------------------
// tb_adc_pedestal_servo
// Self-checking bench for the pedestal servo. Every transfer into the block
// is run through a predictor that holds its own copy of the sums, counts,
// pedestals and positions, and every result is checked field by field
// against the oldest expectation. The run covers directed corner cases,
// the largest minimum count and randomised phases over several configurations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adc_pedestal_servo;
  import aps_pkg::*;

  localparam int MODS     = 16;
  localparam int ADCS     = 32;
  localparam int ACC_SIZE = MODS * ADCS;
  localparam int PED_SIZE = MODS * 32;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  adc_pedestal_servo dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [31:0] acc_sum [ACC_SIZE];
  logic [15:0] acc_cnt [ACC_SIZE];
  logic [15:0] ped_mem [PED_SIZE];
  logic [15:0] pos_mem [PED_SIZE];
  logic        veto_q;
  logic [15:0] target_q;
  logic [15:0] min_cnt_q;
  int          quad_map [16] = '{10, 8, 11, 9, 14, 12, 15, 13,
                                 22, 20, 23, 21, 26, 24, 27, 25};

  in_item_t  pending_items [$];
  out_item_t expected_results [$];

  int fails = 0;
  int n_sent = 0, n_checked = 0, n_updates = 0, n_drops = 0, n_reads = 0;

  // step one pedestal toward the target and record its measured position
  function automatic void servo_slot(int slot, int acc);
    logic [31:0] mean;
    logic [15:0] p;
    begin
      mean = (acc_cnt[acc] != 0) ? acc_sum[acc] / acc_cnt[acc] : 32'd0;
      p = ped_mem[slot];
      if (mean != {16'd0, target_q}) begin
        if (acc_sum[acc] == 0) p = (p > 16'd50) ? p - 16'd50 : 16'd0;
        else if (mean > {16'd0, target_q}) p = (p != 16'hFFFF) ? p + 16'd1 : p;
        else p = (p != 0) ? p - 16'd1 : 16'd0;
      end
      ped_mem[slot] = p;
      pos_mem[slot] = (mean > 32'hFFFF) ? 16'hFFFF : mean[15:0];
    end
  endfunction

  function automatic logic run_calibration();
    longint total, active;
    begin
      total = 0;
      active = 0;
      for (int i = 0; i < ACC_SIZE; i++)
        if (acc_cnt[i] != 0) begin
          total += acc_cnt[i];
          active++;
        end
      if (active == 0 || total < longint'(min_cnt_q) * active) return 1'b0;
      for (int m = 0; m < MODS; m++) begin
        if (veto_q) begin
          for (int c = 0; c < 8; c++) servo_slot((m * 8 + c) * 4, m * ADCS + 20 + c);
        end else begin
          for (int k = 0; k < 16; k++)
            servo_slot((m * 8 + k / 4) * 4 + k % 4, m * ADCS + quad_map[k]);
        end
      end
      for (int i = 0; i < ACC_SIZE; i++) begin
        acc_sum[i] = '0;
        acc_cnt[i] = '0;
      end
      return 1'b1;
    end
  endfunction

  // work out the result of one accepted item and queue it
  task automatic predict_result(in_item_t it);
    out_item_t r;
    int a, s;
    logic ok;
    begin
      r = '0;
      a = it.module_req * ADCS + it.adc;
      s = (it.module_req * 8 + it.channel) * 4 + it.ped_index;
      ok = veto_q ? (it.ped_index == 0) : (it.channel < 4);
      case (it.kind)
        KIND_ADD: begin
          if (acc_cnt[a] == 16'hFFFF || {1'b0, acc_sum[a]} + it.value > 33'hFFFFFFFF) begin
            r.sample_dropped = 1'b1;
            n_drops++;
          end else begin
            acc_sum[a] += it.value;
            acc_cnt[a] += 16'd1;
          end
        end
        KIND_UPDATE: begin
          r.updated = run_calibration();
          if (r.updated) n_updates++;
        end
        KIND_WRITE: if (ok) ped_mem[s] = it.value;
        default: if (ok) begin
          r.pedestal_value = ped_mem[s];
          r.position = pos_mem[s];
          n_reads++;
        end
      endcase
      expected_results.push_back(r);
    end
  endtask

  // sender: bursts of random length separated by random gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_result(in_data);
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern that changes mode, with two long hold-offs
  int rx_cycle = 0, hold_left = 0, pat_left = 0, pat_mode = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle == 700 || rx_cycle == 60000) hold_left = 400;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(16, 200);
          pat_mode = $urandom_range(0, 3);
        end else begin
          pat_left--;
        end
        case (pat_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= rx_cycle[2];
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        fails++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        n_checked++;
        if (out_data.updated !== e.updated) begin
          $error("updated: expected %0d, got %0d", e.updated, out_data.updated);
          fails++;
        end
        if (out_data.pedestal_value !== e.pedestal_value) begin
          $error("pedestal_value: expected %0d, got %0d", e.pedestal_value,
                 out_data.pedestal_value);
          fails++;
        end
        if (out_data.position !== e.position) begin
          $error("position: expected %0d, got %0d", e.position, out_data.position);
          fails++;
        end
        if (out_data.sample_dropped !== e.sample_dropped) begin
          $error("sample_dropped: expected %0d, got %0d", e.sample_dropped,
                 out_data.sample_dropped);
          fails++;
        end
      end
    end
  end

  function automatic in_item_t mk(kind_t k, int m, int a, int c, int p, int v);
    in_item_t it;
    begin
      it.kind = k;
      it.module_req = 4'(m);
      it.adc = 5'(a);
      it.channel = 3'(c);
      it.ped_index = 2'(p);
      it.value = 16'(v);
      return it;
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] d);
    begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= d;
      case (idx)
        REG_VETO:   veto_q = d[0];
        REG_TARGET: target_q = d;
        default:    min_cnt_q = d;
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
    end
  endtask

  // hold the sender until every expected result is back
  task automatic drain();
    begin
      do @(posedge clk);
      while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
      repeat (8) @(posedge clk);
    end
  endtask

  // build a random phase: hot ADCs collect samples so updates can pass
  task automatic random_phase(int n);
    int hot_mod [2];
    int hot_adc [4];
    int r, v, m, a;
    begin
      foreach (hot_mod[i]) hot_mod[i] = $urandom_range(0, MODS - 1);
      foreach (hot_adc[i])
        hot_adc[i] = veto_q ? 20 + $urandom_range(0, 7) : quad_map[$urandom_range(0, 15)];
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          case ($urandom_range(0, 5))
            0: v = 0;
            1: v = $urandom_range(0, 65535);
            default: begin
              v = int'(target_q) + $urandom_range(0, 6) - 3;
              if (v < 0) v = 0;
              if (v > 65535) v = 65535;
            end
          endcase
          m = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MODS - 1) : hot_mod[$urandom_range(0, 1)];
          a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, ADCS - 1) : hot_adc[$urandom_range(0, 3)];
          pending_items.push_back(mk(KIND_ADD, m, a, $urandom_range(0, 7),
                                     $urandom_range(0, 3), v));
        end else if (r < 75) begin
          pending_items.push_back(mk(KIND_UPDATE, $urandom_range(0, 15), $urandom_range(0, 31),
                                     $urandom_range(0, 7), $urandom_range(0, 3),
                                     $urandom_range(0, 65535)));
        end else begin
          pending_items.push_back(mk((r < 87) ? KIND_WRITE : KIND_READ, $urandom_range(0, 15),
                                     $urandom_range(0, 31), $urandom_range(0, 7),
                                     $urandom_range(0, 3), $urandom_range(0, 65535)));
        end
      end
      pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    end
  endtask

  initial begin
    veto_q = 1'b0;
    target_q = TARGET_RESET;
    min_cnt_q = MINCNT_RESET;
    for (int i = 0; i < ACC_SIZE; i++) begin
      acc_sum[i] = '0;
      acc_cnt[i] = '0;
    end
    for (int i = 0; i < PED_SIZE; i++) begin
      ped_mem[i] = '0;
      pos_mem[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset values, pedestal extremes, unused slots, no data, short of minimum
    pending_items.push_back(mk(KIND_READ, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_WRITE, 0, 0, 0, 0, 65535));
    pending_items.push_back(mk(KIND_WRITE, 15, 0, 3, 3, 16'h1234));
    pending_items.push_back(mk(KIND_READ, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 15, 31, 3, 3, 0));
    pending_items.push_back(mk(KIND_WRITE, 1, 0, 5, 0, 77));
    pending_items.push_back(mk(KIND_READ, 1, 0, 5, 0, 0));
    pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 0, 10, 0, 0, 200));
    pending_items.push_back(mk(KIND_ADD, 15, 25, 0, 0, 0));
    pending_items.push_back(mk(KIND_ADD, 2, 8, 0, 0, 65535));
    pending_items.push_back(mk(KIND_ADD, 0, 31, 7, 3, 1));
    pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    drain();

    // minimum of zero: step up to the ceiling, zero-sum step, floor at zero
    write_reg(REG_MINCNT, 16'd0);
    pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 15, 0, 3, 3, 0));
    pending_items.push_back(mk(KIND_READ, 2, 0, 0, 1, 0));
    drain();

    // veto mode with target zero: mean on target leaves the pedestal alone
    write_reg(REG_VETO, 16'd1);
    write_reg(REG_TARGET, 16'd0);
    pending_items.push_back(mk(KIND_WRITE, 4, 0, 7, 0, 5));
    pending_items.push_back(mk(KIND_ADD, 4, 27, 0, 0, 0));
    pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 4, 0, 7, 0, 0));
    pending_items.push_back(mk(KIND_READ, 4, 0, 2, 1, 0));
    drain();

    // largest target and minimum: a short run of samples stays below it
    write_reg(REG_VETO, 16'd0);
    write_reg(REG_TARGET, 16'd65535);
    write_reg(REG_MINCNT, 16'd65535);
    for (int i = 0; i < 20; i++)
      pending_items.push_back(mk(KIND_ADD, 3, 9, 0, 0, $urandom_range(0, 65535)));
    pending_items.push_back(mk(KIND_UPDATE, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_READ, 3, 0, 0, 3, 0));
    drain();

    // random phases over a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_VETO, 16'($urandom_range(0, 1)));
      case (ph % 4)
        0: write_reg(REG_TARGET, 16'd0);
        1: write_reg(REG_TARGET, 16'hFFFF);
        default: write_reg(REG_TARGET, 16'($urandom_range(0, 300)));
      endcase
      write_reg(REG_MINCNT, (ph == 7) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 3)));
      random_phase(120);
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d items, %0d results checked: %0d calibrations applied,",
             n_sent, n_checked, n_updates);
    $display("%0d samples dropped at saturation, %0d pedestal reads", n_drops, n_reads);
    if (fails == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // time limit
  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
